// ===== rtl/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue package
// Shared field widths, operation codes, status codes and the memory control
// group that passes between the level controller and the byte store.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int PRIO_W = 3;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control group for one access of the byte store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/mlpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue level controller
// Holds the head and count of every level, decodes one registered word per
// cycle and produces the store access and the status of the result.
// ----------------------------------------------------------------------------
module mlpq_ctrl
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 5,
  parameter int LEVEL_DEPTH = 16,
  parameter int ADDR_W      = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_vld,
  input  opcode_t           op,
  input  logic [DATA_W-1:0] data,
  input  logic [PRIO_W-1:0] prio,
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [DATA_W-1:0] mem_wdata,
  output status_t           res_status,
  output logic [PRIO_W-1:0] res_prio,
  output logic              res_hit
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r    [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [NUM_LEVELS];
  logic [PTR_W-1:0] head_r   [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt [NUM_LEVELS];

  logic [LVL_W-1:0] enq_lv;
  logic [LVL_W-1:0] deq_lv;
  logic             deq_found;
  logic             enq_full;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail_slot;
  logic [PTR_W-1:0] deq_slot;

  // Out-of-range priorities saturate to the lowest or highest level.
  always_comb begin
    if (prio == '0) begin
      enq_lv = '0;
    end else if (int'(prio) > NUM_LEVELS) begin
      enq_lv = LVL_W'(NUM_LEVELS - 1);
    end else begin
      enq_lv = LVL_W'(prio - PRIO_W'(1));
    end
  end

  // Highest non-empty level wins.
  always_comb begin
    deq_lv    = '0;
    deq_found = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        deq_lv    = LVL_W'(i);
        deq_found = 1'b1;
      end
    end
  end

  assign enq_full = (cnt_r[enq_lv] == CNT_W'(LEVEL_DEPTH));
  assign tail_sum = (PTR_W+1)'(head_r[enq_lv]) + (PTR_W+1)'(cnt_r[enq_lv]);
  assign tail_slot = (tail_sum >= (PTR_W+1)'(LEVEL_DEPTH))
                   ? PTR_W'(tail_sum - (PTR_W+1)'(LEVEL_DEPTH))
                   : PTR_W'(tail_sum);
  assign deq_slot = head_r[deq_lv];

  always_comb begin
    mem_ctl    = '0;
    mem_addr   = '0;
    mem_wdata  = data;
    res_status = ST_OK;
    res_prio   = '0;
    res_hit    = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      head_nxt[i] = head_r[i];
    end
    if (op_vld) begin
      case (op)
        OP_ENQ: begin
          if (enq_full) begin
            res_status = ST_FULL;
          end else begin
            mem_ctl.wr_en   = 1'b1;
            mem_addr        = ADDR_W'(enq_lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_slot);
            cnt_nxt[enq_lv] = cnt_r[enq_lv] + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (!deq_found) begin
            res_status = ST_EMPTY;
          end else begin
            mem_ctl.rd_en    = 1'b1;
            mem_addr         = ADDR_W'(deq_lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(deq_slot);
            res_hit          = 1'b1;
            res_prio         = PRIO_W'((LVL_W+1)'(deq_lv) + (LVL_W+1)'(1));
            cnt_nxt[deq_lv]  = cnt_r[deq_lv] - CNT_W'(1);
            head_nxt[deq_lv] = (deq_slot == PTR_W'(LEVEL_DEPTH - 1))
                             ? '0 : deq_slot + PTR_W'(1);
          end
        end
        OP_FLUSH: begin
          for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_nxt[i]  = '0;
            head_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        head_r[i] <= head_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/mlpq_store.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue byte store
// One memory holding every level's ring, one access per cycle, with the read
// data registered.
// ----------------------------------------------------------------------------
module mlpq_store
  import mlpq_pkg::*;
#(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  mem_ctl_t          mem_ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/multilevel_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue unit
// Byte queue with several priority levels, each a FIFO ring; dequeue serves
// the oldest byte of the highest non-empty level.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Word
//   -------   ------------------   ------------------------------------------
//   input     start / busy         in_opcode, in_data_byte, in_priority_req
//   result    out_valid (strobe)   out_byte, out_priority, out_status
//
// A word is accepted on every rising edge where start is high and busy is low.
// Busy is never raised: one word is taken each cycle. Each word gives exactly
// one result, strobed on out_valid once it has passed the input register and
// then the level controller and store access into the result register.
// The rate is set by the single port of the byte store, which serves one
// access per cycle, so results come out at the rate words go in.
// A synchronous active-low reset empties every level; the byte store itself
// is not cleared, since only occupied entries are ever read.
// The receiver cannot stall the result; it must take each strobe as it comes.
//
module multilevel_priority_queue_unit
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 5,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [DATA_W-1:0] in_data_byte,
  input  logic [PRIO_W-1:0] in_priority_req,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_byte,
  output logic [PRIO_W-1:0] out_priority,
  output logic [ST_W-1:0]   out_status
);

  localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Input register stage.
  logic              in_vld_r;
  opcode_t           op_r;
  logic [DATA_W-1:0] data_r;
  logic [PRIO_W-1:0] prio_r;

  // Controller outputs.
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;
  status_t           res_status;
  logic [PRIO_W-1:0] res_prio;
  logic              res_hit;

  // Result register stage; the dequeued byte arrives from the store's own
  // read register in the same cycle.
  logic              out_vld_r;
  status_t           status_r;
  logic [PRIO_W-1:0] prio_out_r;
  logic              hit_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= opcode_t'(in_opcode);
      data_r <= in_data_byte;
      prio_r <= in_priority_req;
    end
  end

  mlpq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_vld     (in_vld_r),
    .op         (op_r),
    .data       (data_r),
    .prio       (prio_r),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res_status (res_status),
    .res_prio   (res_prio),
    .res_hit    (res_hit)
  );

  mlpq_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= res_status;
    prio_out_r <= res_prio;
    hit_r      <= res_hit;
  end

  // Only a successful dequeue shows a byte; every other result reads zero.
  assign out_valid    = out_vld_r;
  assign out_byte     = hit_r ? mem_rdata : '0;
  assign out_priority = prio_out_r;
  assign out_status   = status_r;

endmodule
